// ----- src/cdrh_pkg.sv -----
// Package for the coefficient decompose / round / hint block.
// Holds command codes, register indexes, CSR widths and reset values.
// No dependencies.
package cdrh_pkg;

   typedef enum logic [1:0] {
      CMD_DECOMPOSE   = 2'd0,
      CMD_POWER2ROUND = 2'd1,
      CMD_MAKE_HINT   = 2'd2,
      CMD_USE_HINT    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_MODULUS    = 2'd0,
      REG_GAMMA      = 2'd1,
      REG_HIGH_COUNT = 2'd2,
      REG_ROUND_BITS = 2'd3
   } reg_idx_type;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int RBITS_W    = 6;

   localparam logic [CSR_DATA_W-1:0] RST_MODULUS    = 64'd8380417;
   localparam logic [CSR_DATA_W-1:0] RST_GAMMA      = 64'd523776;
   localparam logic [CSR_DATA_W-1:0] RST_HIGH_COUNT = 64'd16;
   localparam logic [RBITS_W-1:0]    RST_ROUND_BITS = 6'd13;

endpackage

// ----- src/cdrh_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Depends on nothing; width follows COEFF_BITS.
interface cdrh_req_if #(parameter int COEFF_BITS = 62);
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [COEFF_BITS-1:0] coeff_a;
   logic [COEFF_BITS-1:0] coeff_b;
   modport source (output valid, cmd, coeff_a, coeff_b, input ready);
   modport sink   (input valid, cmd, coeff_a, coeff_b, output ready);
endinterface

interface cdrh_rsp_if #(parameter int COEFF_BITS = 62);
   logic                  valid;
   logic                  ready;
   logic [COEFF_BITS-1:0] main_out;
   logic [COEFF_BITS-1:0] low_out;
   modport source (output valid, main_out, low_out, input ready);
   modport sink   (input valid, main_out, low_out, output ready);
endinterface

// ----- src/cdrh_div_cell.sv -----
// One restoring-division step for LANES lanes, registered.
// Used by cdrh_div_chain; no package dependency.
module cdrh_div_cell #(
   parameter int N      = 64,
   parameter int DW     = 62,
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [DW-1:0]               divisor,
   input  logic                        in_vld,
   input  logic [LANES-1:0]            in_byp,
   input  logic [LANES-1:0][N-1:0]     in_rem,
   input  logic [LANES-1:0][N-1:0]     in_nq,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_vld,
   output logic [LANES-1:0]            out_byp,
   output logic [LANES-1:0][N-1:0]     out_rem,
   output logic [LANES-1:0][N-1:0]     out_nq,
   output logic [SIDE_W-1:0]           out_side
);

   logic                    vld_ff;
   logic [LANES-1:0]        byp_ff;
   logic [LANES-1:0][N-1:0] rem_ff, rem_in;
   logic [LANES-1:0][N-1:0] nq_ff, nq_in;
   logic [SIDE_W-1:0]       side_ff;
   logic [LANES-1:0][N-1:0] trial;
   logic [LANES-1:0][N-1:0] dext;
   logic [LANES-1:0]        ge;

   // bypassed lanes divide by zero: remainder ends up equal to the dividend
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trial[l]  = {in_rem[l][N-2:0], in_nq[l][N-1]};
         dext[l]   = in_byp[l] ? '0 : {{(N-DW){1'b0}}, divisor};
         ge[l]     = trial[l] >= dext[l];
         rem_in[l] = ge[l] ? (trial[l] - dext[l]) : trial[l];
         nq_in[l]  = {in_nq[l][N-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         byp_ff  <= in_byp;
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_byp  = byp_ff;
   assign out_rem  = rem_ff;
   assign out_nq   = nq_ff;
   assign out_side = side_ff;

endmodule

// ----- src/cdrh_div_chain.sv -----
// Row of N division steps: a full N-bit restoring divide, one bit per stage.
// Depends on cdrh_div_cell.
module cdrh_div_chain #(
   parameter int N      = 64,
   parameter int DW     = 62,
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [DW-1:0]               divisor,
   input  logic                        in_vld,
   input  logic [LANES-1:0]            in_byp,
   input  logic [LANES-1:0][N-1:0]     in_num,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_vld,
   output logic [LANES-1:0][N-1:0]     out_rem,
   output logic [LANES-1:0][N-1:0]     out_quo,
   output logic [SIDE_W-1:0]           out_side
);

   logic [N:0]                       vld_l;
   logic [N:0][LANES-1:0]            byp_l;
   logic [N:0][LANES-1:0][N-1:0]     rem_l;
   logic [N:0][LANES-1:0][N-1:0]     nq_l;
   logic [N:0][SIDE_W-1:0]           side_l;

   assign vld_l[0]  = in_vld;
   assign byp_l[0]  = in_byp;
   assign rem_l[0]  = '0;
   assign nq_l[0]   = in_num;
   assign side_l[0] = in_side;

   for (genvar i = 0; i < N; i++) begin : g_step
      cdrh_div_cell #(
         .N(N), .DW(DW), .LANES(LANES), .SIDE_W(SIDE_W)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .divisor (divisor),
         .in_vld  (vld_l[i]),
         .in_byp  (byp_l[i]),
         .in_rem  (rem_l[i]),
         .in_nq   (nq_l[i]),
         .in_side (side_l[i]),
         .out_vld (vld_l[i+1]),
         .out_byp (byp_l[i+1]),
         .out_rem (rem_l[i+1]),
         .out_nq  (nq_l[i+1]),
         .out_side(side_l[i+1])
      );
   end

   assign out_vld  = vld_l[N] & ~(&byp_l[N] & 1'b0);
   assign out_rem  = rem_l[N];
   assign out_quo  = nq_l[N];
   assign out_side = side_l[N];

endmodule

// ----- src/cdrh_csr.sv -----
// APB-style register file: modulus, gamma, high_count, round_bits.
// Depends on cdrh_pkg.
module cdrh_csr #(
   parameter int W = 62
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cdrh_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cdrh_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cdrh_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [W-1:0]                      modulus,
   output logic [W-1:0]                      gamma,
   output logic [W-1:0]                      high_count,
   output logic [cdrh_pkg::RBITS_W-1:0]      round_bits
);

   logic [W-1:0]                 modulus_ff, gamma_ff, high_count_ff;
   logic [cdrh_pkg::RBITS_W-1:0] round_bits_ff;
   cdrh_pkg::reg_idx_type        idx;
   logic                         wr;

   assign idx    = cdrh_pkg::reg_idx_type'(paddr[4:3]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= cdrh_pkg::RST_MODULUS[W-1:0];
         gamma_ff      <= cdrh_pkg::RST_GAMMA[W-1:0];
         high_count_ff <= cdrh_pkg::RST_HIGH_COUNT[W-1:0];
         round_bits_ff <= cdrh_pkg::RST_ROUND_BITS;
      end else if (wr) begin
         case (idx)
            cdrh_pkg::REG_MODULUS:    modulus_ff    <= pwdata[W-1:0];
            cdrh_pkg::REG_GAMMA:      gamma_ff      <= pwdata[W-1:0];
            cdrh_pkg::REG_HIGH_COUNT: high_count_ff <= pwdata[W-1:0];
            cdrh_pkg::REG_ROUND_BITS: round_bits_ff <= pwdata[cdrh_pkg::RBITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         cdrh_pkg::REG_MODULUS:    prdata = {{(cdrh_pkg::CSR_DATA_W-W){1'b0}}, modulus_ff};
         cdrh_pkg::REG_GAMMA:      prdata = {{(cdrh_pkg::CSR_DATA_W-W){1'b0}}, gamma_ff};
         cdrh_pkg::REG_HIGH_COUNT: prdata = {{(cdrh_pkg::CSR_DATA_W-W){1'b0}}, high_count_ff};
         cdrh_pkg::REG_ROUND_BITS:
            prdata = {{(cdrh_pkg::CSR_DATA_W-cdrh_pkg::RBITS_W){1'b0}}, round_bits_ff};
         default: prdata = '0;
      endcase
   end

   assign modulus    = modulus_ff;
   assign gamma      = gamma_ff;
   assign high_count = high_count_ff;
   assign round_bits = round_bits_ff;

endmodule

// ----- src/coeff_decompose_round_hint.sv -----
// Coefficient decompose / power2round / make-hint / use-hint unit, top level.
// Four divider rows of one bit per stage lie between request and response.
// Throughput: one transaction per cycle unless the output register stalls.
// Whole pipeline holds while the output register is full and not taken.
// Reset (sync, active high) clears all valid bits and loads default registers.
// Depends on cdrh_pkg, cdrh_if, cdrh_csr, cdrh_div_chain.
module coeff_decompose_round_hint #(
   parameter int COEFF_BITS = 62
) (
   input  logic                              clock,
   input  logic                              reset,
   cdrh_req_if.sink                          req,
   cdrh_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cdrh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cdrh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cdrh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int W = COEFF_BITS;
   localparam int N = COEFF_BITS + 2;   // room for a+b+gamma/2

   // per-transaction context carried alongside the divider rows
   typedef struct packed {
      cdrh_pkg::cmd_type cmd;
      logic [W-1:0]      a;
      logic              neg_c;   // centered hint sign (use hint)
      logic [N-1:0]      mag_c;
      logic [N-1:0]      p2;      // a + 2^(d-1) - 1 (power2round)
      logic              hneg;
      logic [N-1:0]      hmag;
      logic              lneg;
      logic [N-1:0]      lmag;
   } ctx_type;

   localparam int SIDE_W = $bits(ctx_type);

   logic [W-1:0]                 modulus, gamma_w, high_count;
   logic [cdrh_pkg::RBITS_W-1:0] round_bits;

   cdrh_csr #(.W(W)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .modulus   (modulus),
      .gamma     (gamma_w),
      .high_count(high_count),
      .round_bits(round_bits)
   );

   // global advance: everything moves unless the result register is stuck
   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // shared constants from config
   logic [N-1:0] q_n, hc_n, gm_n;
   logic         g_ok;
   assign q_n  = {2'b00, modulus};
   assign hc_n = {2'b00, high_count};
   assign gm_n = ({2'b00, gamma_w} >> 1) - N'(1);
   assign g_ok = gamma_w >= W'(2);

   // ---------------- entry: pick residue-reduction operands ----------------
   logic                e_vld_ff;
   logic [1:0]          e_byp_ff, e_byp_in;
   logic [1:0][N-1:0]   e_num_ff, e_num_in;
   ctx_type             e_ctx_ff, e_ctx_in;

   always_comb begin
      logic [N-1:0] a_n, b_n;
      a_n = {2'b00, req.coeff_a};
      b_n = {2'b00, req.coeff_b};
      e_ctx_in       = '0;
      e_ctx_in.cmd   = cdrh_pkg::cmd_type'(req.cmd);
      e_ctx_in.a     = req.coeff_a;
      // center the hint about q/2 for use hint
      if (a_n >= (q_n >> 1)) begin
         if (a_n >= q_n) begin
            e_ctx_in.neg_c = 1'b0;
            e_ctx_in.mag_c = a_n - q_n;
         end else begin
            e_ctx_in.neg_c = 1'b1;
            e_ctx_in.mag_c = q_n - a_n;
         end
      end else begin
         e_ctx_in.neg_c = 1'b0;
         e_ctx_in.mag_c = a_n;
      end
      case (e_ctx_in.cmd)
         cdrh_pkg::CMD_MAKE_HINT: begin
            e_num_in = {b_n, a_n + b_n};
            e_byp_in = 2'b00;
         end
         cdrh_pkg::CMD_USE_HINT: begin
            e_num_in = {{N{1'b0}}, b_n};
            e_byp_in = 2'b10;
         end
         default: begin
            e_num_in = {{N{1'b0}}, a_n};
            e_byp_in = 2'b11;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_byp_ff <= e_byp_in;
         e_num_ff <= e_num_in;
         e_ctx_ff <= e_ctx_in;
      end
   end

   // ---------------- row A: x mod q (hint operands) ----------------
   logic               a_vld;
   logic [1:0][N-1:0]  a_rem;
   logic [SIDE_W-1:0]  a_side;
   ctx_type            a_ctx;

   cdrh_div_chain #(.N(N), .DW(W), .LANES(2), .SIDE_W(SIDE_W)) u_row_a (
      .clock(clock), .reset(reset), .en(adv), .divisor(modulus),
      .in_vld(e_vld_ff), .in_byp(e_byp_ff), .in_num(e_num_ff), .in_side(e_ctx_ff),
      .out_vld(a_vld), .out_rem(a_rem), .out_quo(), .out_side(a_side)
   );
   assign a_ctx = ctx_type'(a_side);

   // ---------------- M1: add gamma/2-1, prep power2round ----------------
   logic               m1_vld_ff;
   logic [1:0]         m1_byp_ff, m1_byp_in;
   logic [1:0][N-1:0]  m1_num_ff, m1_num_in;
   ctx_type            m1_ctx_ff, m1_ctx_in;

   always_comb begin
      logic [N-1:0] half_d;
      half_d    = {{(N-1){1'b0}}, 1'b1} << (round_bits - cdrh_pkg::RBITS_W'(1));
      m1_ctx_in = a_ctx;
      m1_ctx_in.p2 = {2'b00, a_ctx.a} + half_d - N'(1);
      m1_num_in = {a_rem[1] + gm_n, a_rem[0] + gm_n};
      case (a_ctx.cmd)
         cdrh_pkg::CMD_POWER2ROUND: m1_byp_in = 2'b11;
         cdrh_pkg::CMD_MAKE_HINT:   m1_byp_in = {!g_ok, !g_ok};
         default:                   m1_byp_in = {1'b1, !g_ok};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= a_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_byp_ff <= m1_byp_in;
         m1_num_ff <= m1_num_in;
         m1_ctx_ff <= m1_ctx_in;
      end
   end

   // ---------------- row B: divide by gamma ----------------
   logic               b_vld;
   logic [1:0][N-1:0]  b_rem, b_quo;
   logic [SIDE_W-1:0]  b_side;
   ctx_type            b_ctx;

   cdrh_div_chain #(.N(N), .DW(W), .LANES(2), .SIDE_W(SIDE_W)) u_row_b (
      .clock(clock), .reset(reset), .en(adv), .divisor(gamma_w),
      .in_vld(m1_vld_ff), .in_byp(m1_byp_ff), .in_num(m1_num_ff), .in_side(m1_ctx_ff),
      .out_vld(b_vld), .out_rem(b_rem), .out_quo(b_quo), .out_side(b_side)
   );
   assign b_ctx = ctx_type'(b_side);

   // ---------------- M2: form signed high/low per command ----------------
   logic              m2_vld_ff;
   logic              m2_byp_ff, m2_byp_in;
   logic [N-1:0]      m2_num_ff;
   ctx_type           m2_ctx_ff, m2_ctx_in;

   always_comb begin
      logic         clx, cly;
      logic [N-1:0] hbx, hby, t, hs, h, a_n;
      a_n = {2'b00, b_ctx.a};
      clx = b_quo[0] >= hc_n;
      cly = b_quo[1] >= hc_n;
      hbx = (!g_ok || clx) ? '0 : b_quo[0];
      hby = (!g_ok || cly) ? '0 : b_quo[1];
      t   = hbx - hby;
      h   = b_ctx.p2 >> round_bits;
      hs  = b_ctx.p2 & ({N{1'b1}} << round_bits);
      m2_ctx_in      = b_ctx;
      m2_ctx_in.hneg = 1'b0;
      m2_ctx_in.hmag = '0;
      m2_ctx_in.lneg = 1'b0;
      m2_ctx_in.lmag = '0;
      m2_byp_in      = 1'b1;
      case (b_ctx.cmd)
         cdrh_pkg::CMD_DECOMPOSE: begin
            if (!g_ok || clx) begin
               m2_ctx_in.lmag = a_n;
            end else begin
               m2_ctx_in.hmag = hbx;
               // a - gamma*h equals the divide remainder less gamma/2-1
               if (b_rem[0] >= gm_n) begin
                  m2_ctx_in.lmag = b_rem[0] - gm_n;
               end else begin
                  m2_ctx_in.lneg = 1'b1;
                  m2_ctx_in.lmag = gm_n - b_rem[0];
               end
            end
         end
         cdrh_pkg::CMD_POWER2ROUND: begin
            if (round_bits == '0) begin
               m2_ctx_in.hmag = a_n;
            end else begin
               m2_ctx_in.hmag = h;
               if (a_n >= hs) begin
                  m2_ctx_in.lmag = a_n - hs;
               end else begin
                  m2_ctx_in.lneg = 1'b1;
                  m2_ctx_in.lmag = hs - a_n;
               end
            end
         end
         cdrh_pkg::CMD_MAKE_HINT: begin
            if (hbx >= hby) begin
               if (t > (hc_n >> 1)) begin
                  m2_ctx_in.hneg = 1'b1;
                  m2_ctx_in.hmag = hc_n - t;
               end else begin
                  m2_ctx_in.hmag = t;
               end
            end else begin
               m2_ctx_in.hneg = 1'b1;
               m2_ctx_in.hmag = hby - hbx;
            end
         end
         cdrh_pkg::CMD_USE_HINT: begin
            m2_byp_in = 1'b0;
            if (b_ctx.neg_c) begin
               if (hbx >= b_ctx.mag_c) begin
                  m2_ctx_in.hmag = hbx - b_ctx.mag_c;
               end else begin
                  m2_ctx_in.hneg = 1'b1;
                  m2_ctx_in.hmag = b_ctx.mag_c - hbx;
               end
            end else begin
               m2_ctx_in.hmag = b_ctx.mag_c + hbx;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (adv) begin
         m2_vld_ff <= b_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_byp_ff <= m2_byp_in;
         m2_num_ff <= m2_ctx_in.hmag;
         m2_ctx_ff <= m2_ctx_in;
      end
   end

   // ---------------- row C: truncating remainder by high_count ----------------
   logic               c_vld;
   logic [0:0][N-1:0]  c_rem;
   logic [SIDE_W-1:0]  c_side;
   ctx_type            c_ctx;

   cdrh_div_chain #(.N(N), .DW(W), .LANES(1), .SIDE_W(SIDE_W)) u_row_c (
      .clock(clock), .reset(reset), .en(adv), .divisor(high_count),
      .in_vld(m2_vld_ff), .in_byp(m2_byp_ff), .in_num(m2_num_ff), .in_side(m2_ctx_ff),
      .out_vld(c_vld), .out_rem(c_rem), .out_quo(), .out_side(c_side)
   );

   // a zero magnitude carries no sign
   always_comb begin
      c_ctx      = ctx_type'(c_side);
      c_ctx.hneg = c_ctx.hneg && (c_rem[0] != '0);
      c_ctx.hmag = c_rem[0];
   end

   // ---------------- row D: final reduction mod q ----------------
   logic               d_vld;
   logic [1:0][N-1:0]  d_rem;
   logic [SIDE_W-1:0]  d_side;
   ctx_type            d_ctx;

   cdrh_div_chain #(.N(N), .DW(W), .LANES(2), .SIDE_W(SIDE_W)) u_row_d (
      .clock(clock), .reset(reset), .en(adv), .divisor(modulus),
      .in_vld(c_vld), .in_byp(2'b00), .in_num({c_ctx.lmag, c_ctx.hmag}),
      .in_side(c_ctx),
      .out_vld(d_vld), .out_rem(d_rem), .out_quo(), .out_side(d_side)
   );
   assign d_ctx = ctx_type'(d_side);

   // ---------------- residue fix-up and output register ----------------
   logic [W-1:0]       main_in, low_in, out_main_ff, out_low_ff;
   cdrh_pkg::cmd_type  out_cmd_ff;

   always_comb begin
      logic [N-1:0] nh, nl;
      nh = '0 - d_ctx.hmag;
      nl = '0 - d_ctx.lmag;
      if (modulus == '0) begin
         // no modulus: plain two's complement, masked
         main_in = d_ctx.hneg ? nh[W-1:0] : d_ctx.hmag[W-1:0];
         low_in  = d_ctx.lneg ? nl[W-1:0] : d_ctx.lmag[W-1:0];
      end else begin
         main_in = (d_ctx.hneg && d_rem[0] != '0) ? modulus - d_rem[0][W-1:0]
                                                  : d_rem[0][W-1:0];
         low_in  = (d_ctx.lneg && d_rem[1] != '0) ? modulus - d_rem[1][W-1:0]
                                                  : d_rem[1][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= d_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_main_ff <= main_in;
         out_low_ff  <= low_in;
         out_cmd_ff  <= d_ctx.cmd;
      end
   end

   assign rsp.valid    = out_vld_ff;
   assign rsp.main_out = out_main_ff;
   assign rsp.low_out  = out_low_ff;

   // ---------------- assertions ----------------
   a_hint_low_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && (out_cmd_ff == cdrh_pkg::CMD_MAKE_HINT ||
                     out_cmd_ff == cdrh_pkg::CMD_USE_HINT) |-> out_low_ff == '0)
      else $error("low_out nonzero on hint transaction");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && modulus != '0 |-> out_main_ff < modulus && out_low_ff < modulus)
      else $error("result not reduced below modulus");

   a_p2r_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_cmd_ff == cdrh_pkg::CMD_POWER2ROUND && round_bits == '0
      |-> out_low_ff == '0)
      else $error("power2round with no dropped bits left a low part");

endmodule
